// ----- rtl/acd_pkg.sv -----
// ----------------------------------------------------------------------------
// acd_pkg
// Shared widths, register codes and the configuration bundle of the
// adaptive clap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

	localparam int SAMPLE_BITS    = 10;
	localparam int FRACTION_BITS  = 16;
	localparam int GAIN_BITS      = 16;
	localparam int SHIFT_BITS     = 3;
	localparam int MARGIN_BITS    = 8;
	localparam int OFFSET_BITS    = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// levels are unsigned Q(SAMPLE_BITS+1).FRACTION_BITS
	localparam int LEVEL_BITS  = SAMPLE_BITS + 1 + FRACTION_BITS;
	localparam int DIFF_BITS   = LEVEL_BITS + 1;
	localparam int SCALED_BITS = DIFF_BITS + (1 << SHIFT_BITS) - 1;
	localparam int BAND_BITS   = SCALED_BITS + 1;

	localparam logic [GAIN_BITS-1:0]   SILENCE_GAIN_RST  = GAIN_BITS'(655);
	localparam logic [GAIN_BITS-1:0]   BORDER_GAIN_RST   = GAIN_BITS'(1311);
	localparam logic [SHIFT_BITS-1:0]  SHIFT_RST         = SHIFT_BITS'(2);
	localparam logic [MARGIN_BITS-1:0] MARGIN_RST        = MARGIN_BITS'(20);
	localparam logic [OFFSET_BITS-1:0] INITIAL_OFFSET_RST = OFFSET_BITS'(100);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SILENCE_GAIN   = 3'd0,
		REG_BORDER_GAIN    = 3'd1,
		REG_INSENS_SHIFT   = 3'd2,
		REG_MARGIN         = 3'd3,
		REG_INITIAL_OFFSET = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]   silence_gain;
		logic [GAIN_BITS-1:0]   border_gain;
		logic [SHIFT_BITS-1:0]  insensitivity_shift;
		logic [MARGIN_BITS-1:0] margin;
		logic [OFFSET_BITS-1:0] initial_offset;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/acd_cfg.sv -----
// ----------------------------------------------------------------------------
// acd_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_cfg import acd_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                           cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.silence_gain        <= SILENCE_GAIN_RST;
			cfg_q.border_gain         <= BORDER_GAIN_RST;
			cfg_q.insensitivity_shift <= SHIFT_RST;
			cfg_q.margin              <= MARGIN_RST;
			cfg_q.initial_offset      <= INITIAL_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SILENCE_GAIN: begin
					cfg_q.silence_gain <= cfg_data[GAIN_BITS-1:0];
				end
				REG_BORDER_GAIN: begin
					cfg_q.border_gain <= cfg_data[GAIN_BITS-1:0];
				end
				REG_INSENS_SHIFT: begin
					cfg_q.insensitivity_shift <= cfg_data[SHIFT_BITS-1:0];
				end
				REG_MARGIN: begin
					cfg_q.margin <= cfg_data[MARGIN_BITS-1:0];
				end
				REG_INITIAL_OFFSET: begin
					cfg_q.initial_offset <= cfg_data[OFFSET_BITS-1:0];
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/acd_track.sv -----
// ----------------------------------------------------------------------------
// acd_track
// Level tracker: first-order filters for the silence and clap levels,
// updated once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_track import acd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   update,
	input  wire logic [SAMPLE_BITS-1:0] sample_s1,
	output logic [LEVEL_BITS-1:0]       silence_level,
	output logic [LEVEL_BITS-1:0]       clap_level
);

	logic                  primed_q;
	logic [LEVEL_BITS-1:0] silence_q;
	logic [LEVEL_BITS-1:0] clap_q;

	logic [LEVEL_BITS-1:0]    target;
	logic [SAMPLE_BITS:0]     start_int;
	logic [LEVEL_BITS-1:0]    base_sil;
	logic [LEVEL_BITS-1:0]    base_clap;
	logic [LEVEL_BITS-1:0]    next_sil;
	logic [LEVEL_BITS-1:0]    filt_clap;
	logic [LEVEL_BITS-1:0]    next_clap;

	// level + floor((target - level) * gain / 2^GAIN_BITS)
	function automatic logic [LEVEL_BITS-1:0] filter_step(
		input logic [LEVEL_BITS-1:0] level,
		input logic [LEVEL_BITS-1:0] tgt,
		input logic [GAIN_BITS-1:0]  gain
	);
		logic signed [DIFF_BITS-1:0]           diff;
		logic signed [GAIN_BITS:0]             gain_s;
		logic signed [DIFF_BITS+GAIN_BITS:0]   prod;
		logic signed [DIFF_BITS+GAIN_BITS:0]   shifted;
		logic [DIFF_BITS:0]                    sum;
		diff    = $signed({1'b0, tgt}) - $signed({1'b0, level});
		gain_s  = $signed({1'b0, gain});
		prod    = diff * gain_s;
		shifted = prod >>> GAIN_BITS;
		sum     = {2'b00, level} + shifted[DIFF_BITS:0];
		// the true result lies between level and target, so it fits
		return sum[LEVEL_BITS-1:0];
	endfunction

	always_comb begin
		target    = {1'b0, sample_s1, {FRACTION_BITS{1'b0}}};
		start_int = (SAMPLE_BITS+1)'(sample_s1) + (SAMPLE_BITS+1)'(cfg.initial_offset);
		base_sil  = primed_q ? silence_q : target;
		base_clap = primed_q ? clap_q : {start_int, {FRACTION_BITS{1'b0}}};
		next_sil  = filter_step(base_sil, target, cfg.silence_gain);
		filt_clap = filter_step(base_clap, target, cfg.border_gain);
		// follow only samples above the new silence level
		next_clap = (target > next_sil) ? filt_clap : base_clap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q  <= 1'b0;
			silence_q <= '0;
			clap_q    <= '0;
		end else if (update) begin
			primed_q  <= 1'b1;
			silence_q <= next_sil;
			clap_q    <= next_clap;
		end
	end

	assign silence_level = silence_q;
	assign clap_level    = clap_q;

	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped");

	a_primed_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		update |=> primed_q)
		else $error("levels not marked loaded after update");

	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!update |=> ($stable(silence_q) && $stable(clap_q)))
		else $error("levels moved without an item");

endmodule

`default_nettype wire

// ----- rtl/acd_judge.sv -----
// ----------------------------------------------------------------------------
// acd_judge
// Threshold test of a sample against the band around the silence level,
// with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module acd_judge import acd_pkg::*; (
	input  wire logic                   clk,
	input  wire cfg_t                   cfg,
	input  wire logic                   load,
	input  wire logic [SAMPLE_BITS-1:0] sample_s2,
	input  wire logic [LEVEL_BITS-1:0]  silence_level,
	input  wire logic [LEVEL_BITS-1:0]  clap_level,
	output logic                        clap
);

	logic signed [DIFF_BITS-1:0]                 spread;
	logic signed [SCALED_BITS-1:0]               spread_x;
	logic signed [SCALED_BITS-1:0]               scaled;
	logic signed [MARGIN_BITS+FRACTION_BITS:0]   margin_fx;
	logic signed [BAND_BITS-1:0]                 band;
	logic signed [DIFF_BITS-1:0]                 deviation;
	logic signed [BAND_BITS-1:0]                 deviation_x;
	logic                                        hit;
	logic                                        clap_q;

	always_comb begin
		spread      = $signed({1'b0, clap_level}) - $signed({1'b0, silence_level});
		spread_x    = SCALED_BITS'(spread);
		scaled      = spread_x <<< cfg.insensitivity_shift;
		margin_fx   = {1'b0, cfg.margin, {FRACTION_BITS{1'b0}}};
		band        = BAND_BITS'(scaled) + BAND_BITS'(margin_fx);
		deviation   = $signed({2'b00, sample_s2, {FRACTION_BITS{1'b0}}})
			- $signed({1'b0, silence_level});
		deviation_x = BAND_BITS'(deviation);
		// above the upper or below the lower threshold
		hit         = (deviation_x > band) || (-deviation_x > band);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			clap_q <= hit;
		end
	end

	assign clap = clap_q;

endmodule

`default_nettype wire

// ----- rtl/adaptive_clap_detector.sv -----
// ----------------------------------------------------------------------------
// adaptive_clap_detector
// Adaptive clap detector: tracks silence and clap levels of a microphone
// stream and flags samples outside the adaptive band.
//
//   channel   signals                          direction  payload
//   input     in_valid / in_ready              in         sample[9:0]
//   output    out_valid / out_ready            out        clap
//   config    cfg_we, cfg_index, cfg_data      in         register write
//
// One item per cycle sustained while out_ready stays high; out_valid rises once
// the item has passed the input register, the level update and the threshold
// test into the result register. The level filters close their feedback loop
// through the level registers alone. Reset clears the configuration to
// defaults and the levels to unloaded. A stalled result holds the pipeline;
// in_ready drops only when all three stages are full and out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_clap_detector import acd_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [SAMPLE_BITS-1:0]    sample,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           clap,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic                   adv_s1;
	logic                   adv_s2;
	logic                   in_fire;
	logic                   update;
	logic                   judge_load;
	logic [LEVEL_BITS-1:0]  silence_level;
	logic [LEVEL_BITS-1:0]  clap_level;

	assign adv_s2     = !out_valid_q || out_ready;
	assign adv_s1     = !valid_s2 || adv_s2;
	assign in_ready   = !valid_s1 || adv_s1;
	assign in_fire    = in_valid && in_ready;
	assign update     = valid_s1 && adv_s1;
	assign judge_load = valid_s2 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s2) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= sample;
		end
		if (update) begin
			sample_s2 <= sample_s1;
		end
	end

	acd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	acd_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.update        (update),
		.sample_s1     (sample_s1),
		.silence_level (silence_level),
		.clap_level    (clap_level)
	);

	acd_judge u_judge (
		.clk           (clk),
		.cfg           (cfg),
		.load          (judge_load),
		.sample_s2     (sample_s2),
		.silence_level (silence_level),
		.clap_level    (clap_level),
		.clap          (clap)
	);

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive clap detector. Samples go in with
// bursty valid while the result side stalls on its own pattern. A local
// level tracker predicts every clap flag, and results are compared in order.
// Register settings change only while the block is drained.
// ----------------------------------------------------------------------------

module testbench;
	import acd_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 12;
	localparam int IDLE_LIMIT      = 5000;
	localparam int HOLD_CYCLES     = 300;
	localparam int REPORT_LIMIT    = 10;
	localparam int RANDOM_ITEMS    = 1850;
	localparam int FIRST_SPARE_REG = 5;
	localparam int LAST_SPARE_REG  = (1 << CFG_INDEX_BITS) - 1;
	localparam int SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
	localparam int SHIFT_TOP       = (1 << SHIFT_BITS) - 1;
	localparam int SHIFT_NOMINAL_TOP = 4;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_EVERY_THIRD
	} ready_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [SAMPLE_BITS-1:0]    sample;
	logic                      out_valid;
	logic                      out_ready;
	logic                      clap;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	adaptive_clap_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.clap      (clap),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the detector state and its registers
	cfg_t   level_cfg;
	logic   levels_loaded;
	longint silence_lvl;
	longint clap_lvl;

	logic clap_expected[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_claps = 0;
	int n_errors = 0;
	int n_settings = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int hold_request = 0;
	int hold_left = 0;
	int mode_left = 0;
	int rx_cycle = 0;
	ready_mode_t ready_mode = READY_ALWAYS;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic logic predict_clap(input logic [SAMPLE_BITS-1:0] value);
		longint target;
		longint spread;
		longint scaled;
		longint band_edge;
		longint top;
		longint bottom;
		target = longint'(value) << FRACTION_BITS;
		if (!levels_loaded) begin
			silence_lvl = target;
			clap_lvl = (longint'(value) + longint'(level_cfg.initial_offset)) << FRACTION_BITS;
			levels_loaded = 1'b1;
		end
		// arithmetic shift of the signed product rounds toward minus infinity
		silence_lvl = silence_lvl
			+ (((target - silence_lvl) * longint'(level_cfg.silence_gain)) >>> GAIN_BITS);
		if (target > silence_lvl)
			clap_lvl = clap_lvl
				+ (((target - clap_lvl) * longint'(level_cfg.border_gain)) >>> GAIN_BITS);
		spread = clap_lvl - silence_lvl;
		scaled = spread * (longint'(1) << level_cfg.insensitivity_shift);
		band_edge = longint'(level_cfg.margin) << FRACTION_BITS;
		top = silence_lvl + scaled + band_edge;
		bottom = silence_lvl - scaled - band_edge;
		return (target > top) || (target < bottom);
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!in_ready);
		clap_expected.push_back(predict_clap(value));
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (clap_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (index)
			REG_SILENCE_GAIN:   level_cfg.silence_gain = data[GAIN_BITS-1:0];
			REG_BORDER_GAIN:    level_cfg.border_gain = data[GAIN_BITS-1:0];
			REG_INSENS_SHIFT:   level_cfg.insensitivity_shift = data[SHIFT_BITS-1:0];
			REG_MARGIN:         level_cfg.margin = data[MARGIN_BITS-1:0];
			REG_INITIAL_OFFSET: level_cfg.initial_offset = data[OFFSET_BITS-1:0];
			default: ;
		endcase
	endtask

	// narrow registers get random upper data bits, which the block must drop
	task automatic write_setting(input cfg_t c);
		logic [CFG_DATA_BITS-1:0] data;
		data = CFG_DATA_BITS'($urandom);
		data[GAIN_BITS-1:0] = c.silence_gain;
		write_reg(REG_SILENCE_GAIN, data);
		data = CFG_DATA_BITS'($urandom);
		data[GAIN_BITS-1:0] = c.border_gain;
		write_reg(REG_BORDER_GAIN, data);
		data = CFG_DATA_BITS'($urandom);
		data[SHIFT_BITS-1:0] = c.insensitivity_shift;
		write_reg(REG_INSENS_SHIFT, data);
		data = CFG_DATA_BITS'($urandom);
		data[MARGIN_BITS-1:0] = c.margin;
		write_reg(REG_MARGIN, data);
		data = CFG_DATA_BITS'($urandom);
		data[OFFSET_BITS-1:0] = c.initial_offset;
		write_reg(REG_INITIAL_OFFSET, data);
		n_settings++;
	endtask

	task automatic write_spare_regs();
		for (int i = FIRST_SPARE_REG; i <= LAST_SPARE_REG; i++)
			write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom));
	endtask

	function automatic cfg_t default_setting();
		cfg_t c;
		c.silence_gain = SILENCE_GAIN_RST;
		c.border_gain = BORDER_GAIN_RST;
		c.insensitivity_shift = SHIFT_RST;
		c.margin = MARGIN_RST;
		c.initial_offset = INITIAL_OFFSET_RST;
		return c;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_TOP)
			return SAMPLE_BITS'(SAMPLE_TOP);
		return SAMPLE_BITS'(v);
	endfunction

	// quiet baseline with noise, occasional spikes, some raw noise and rails
	function automatic logic [SAMPLE_BITS-1:0] next_sample(input int base);
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 5)
			return clamp_sample(base + $urandom_range(0, 16) - 8);
		if (kind <= 7)
			return clamp_sample(base + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(40, 600));
		if (kind == 8)
			return SAMPLE_BITS'($urandom);
		return $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_TOP) : '0;
	endfunction

	task automatic test_first_sample();
		logic [SAMPLE_BITS-1:0] seq[12];
		seq = '{512, 512, SAMPLE_TOP, 0, SAMPLE_TOP, 0, 600, 400, 512, 513, 511, SAMPLE_TOP};
		foreach (seq[i])
			send_sample(seq[i]);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		cfg_t c;
		// writes to unused indexes must leave the settings alone
		write_spare_regs();
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		wait_drained();

		c = default_setting();
		c.silence_gain = '0;
		c.border_gain = '0;
		write_setting(c);
		send_sample('0);
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		wait_drained();

		c.silence_gain = '1;
		c.border_gain = '1;
		c.insensitivity_shift = SHIFT_BITS'(SHIFT_TOP);
		c.margin = '0;
		c.initial_offset = '1;
		write_setting(c);
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		send_sample('0);
		send_sample('0);
		// pull the clap level down to a low sample
		send_sample(SAMPLE_BITS'(100));
		wait_drained();

		// freeze the clap level and drive silence above it
		c.border_gain = '0;
		c.insensitivity_shift = SHIFT_BITS'(5);
		write_setting(c);
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		send_sample(SAMPLE_BITS'(SAMPLE_TOP));
		send_sample(SAMPLE_BITS'(500));
		wait_drained();
		write_setting(default_setting());
	endtask

	task automatic test_output_stall();
		int base;
		base = $urandom_range(100, 900);
		hold_request = 1;
		for (int i = 0; i < 40; i++)
			send_sample(next_sample(base));
		wait_drained();
	endtask

	task automatic test_random_settings();
		cfg_t c;
		int base;
		int n_items;
		int sent_here;
		sent_here = 0;
		while (sent_here < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				c.silence_gain = $urandom_range(0, 1) ? '1 : '0;
				c.border_gain = $urandom_range(0, 1) ? '1 : '0;
				case ($urandom_range(0, 2))
					0: c.insensitivity_shift = '0;
					1: c.insensitivity_shift = SHIFT_BITS'(SHIFT_NOMINAL_TOP);
					default: c.insensitivity_shift = SHIFT_BITS'(SHIFT_TOP);
				endcase
				c.margin = $urandom_range(0, 1) ? '1 : '0;
				c.initial_offset = $urandom_range(0, 1) ? '1 : '0;
			end else begin
				c.silence_gain = GAIN_BITS'($urandom);
				c.border_gain = GAIN_BITS'($urandom);
				c.insensitivity_shift = $urandom_range(0, 3) == 0
					? SHIFT_BITS'($urandom) : SHIFT_BITS'($urandom_range(0, SHIFT_NOMINAL_TOP));
				c.margin = MARGIN_BITS'($urandom);
				c.initial_offset = OFFSET_BITS'($urandom);
			end
			write_setting(c);
			if ($urandom_range(0, 4) == 0)
				write_spare_regs();
			base = $urandom_range(0, SAMPLE_TOP);
			n_items = $urandom_range(20, 120);
			for (int i = 0; i < n_items; i++) begin
				// let the baseline wander now and then
				if ($urandom_range(0, 31) == 0)
					base = $urandom_range(0, SAMPLE_TOP);
				send_sample(next_sample(base));
			end
			sent_here += n_items;
			wait_drained();
		end
	endtask

	// result side: changes its stall pattern at random, plus long hold-offs
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_request != 0) begin
			hold_left = HOLD_CYCLES;
			hold_request = 0;
		end
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(5, 120);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
				READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:      out_ready <= (rx_cycle % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (clap_expected.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_LIMIT)
					$display("unexpected result: clap=%0b with nothing pending", clap);
			end else begin
				want = clap_expected.pop_front();
				n_checked++;
				if (clap === 1'b1)
					n_claps++;
				if (clap !== want) begin
					n_errors++;
					if (n_errors <= REPORT_LIMIT)
						$display("mismatch on result %0d: expected clap=%0b, got %0b",
							n_checked, want, clap);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (!in_valid && clap_expected.size() == 0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results pending",
				idle_cycles, clap_expected.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		level_cfg = default_setting();
		levels_loaded = 1'b0;
		silence_lvl = 0;
		clap_lvl = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample();
		test_register_extremes();
		test_output_stall();
		test_random_settings();

		wait_drained();
		repeat (10) @(posedge clk);
		if (clap_expected.size() != 0)
			n_errors++;
		$display("covered %0d samples over %0d register settings, %0d flagged as claps",
			n_sent, n_settings, n_claps);
		$display("checked %0d results, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/acd_pkg.sv
rtl/acd_cfg.sv
rtl/acd_track.sv
rtl/acd_judge.sv
rtl/adaptive_clap_detector.sv
verif/testbench.sv
